>>> sv/pmp_pkg.sv
// Shared types, constants and helper functions of the polygon mass properties block.
package pmp_pkg;

    // Default depth of the point chain.
    localparam int MAX_POINTS_DEF = 16;

    // Width of the wide accumulators, divider operands and products.
    localparam int ACC_W = 176;
    // Width of the multiplier operand that is scanned one bit a cycle.
    localparam int MUL_B_W = 72;

    // Rod divisors for one point (about a given centre) and two points (about the midpoint).
    localparam int ROD_END_DIV = 3;
    localparam int ROD_MID_DIV = 12;

    // Angular classes of a point around the mean.
    localparam logic [1:0] CLS_LOW  = 2'd0;
    localparam logic [1:0] CLS_POSX = 2'd1;
    localparam logic [1:0] CLS_HIGH = 2'd2;
    localparam logic [1:0] CLS_NEGX = 2'd3;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] mass_value;
        logic signed [31:0] given_centre_x;
        logic signed [31:0] given_centre_y;
        logic               last_point;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic [62:0]        moment_of_inertia;
        logic [31:0]        mass_out;
        logic               error_flag;
    } t_out_word;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_ROT,
        CELL_RANK,
        CELL_SWAP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK_CUR,
        ST_RANK_CMP,
        ST_RANK_WR,
        ST_RANK_NXT,
        ST_SORT,
        ST_PASS_A,
        ST_DIV_CX,
        ST_DIV_CY,
        ST_PASS_B,
        ST_SQ,
        ST_NUM,
        ST_DIV_I,
        ST_DONE
    } t_state;

    // Class of a point from the signs of its offset from the mean.
    function automatic logic [1:0] angle_class(input logic yneg, input logic yzero,
                                               input logic xneg);
        logic [1:0] c;
        if (yneg) begin
            c = CLS_LOW;
        end else if (yzero && !xneg) begin
            c = CLS_POSX;
        end else if (!yzero) begin
            c = CLS_HIGH;
        end else begin
            c = CLS_NEGX;
        end
        return c;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < ACC_W'(-64'sd2147483648)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a wide signed value to the unsigned 63-bit range.
    function automatic logic [62:0] sat63(input logic signed [ACC_W-1:0] v);
        logic [62:0] r;
        if (v[ACC_W-1]) begin
            r = '0;
        end else if (v[ACC_W-2:63] != '0) begin
            r = '1;
        end else begin
            r = v[62:0];
        end
        return r;
    endfunction

endpackage

>>> sv/pmp_cell.sv
// One cell of the point chain: holds a point, its load index and its angular rank.
module pmp_cell #(
    parameter int K          = 0,
    parameter int MAX_POINTS = pmp_pkg::MAX_POINTS_DEF
) (
    input  logic                                         i_clk,
    input  pmp_pkg::t_cell_ctl                           i_ctl,
    input  logic [$clog2(MAX_POINTS+1)-1:0]              i_n,
    input  logic [$clog2(MAX_POINTS+1)-1:0]              i_wr_idx,
    input  logic [63:0]                                  i_ld_point,
    input  logic [$clog2(MAX_POINTS)-1:0]                i_rank,
    input  logic [64+2*$clog2(MAX_POINTS)-1:0]           i_left,
    input  logic [64+2*$clog2(MAX_POINTS)-1:0]           i_right,
    input  logic [64+2*$clog2(MAX_POINTS)-1:0]           i_head,
    output logic [64+2*$clog2(MAX_POINTS)-1:0]           o_val
);
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CELL_W = 64 + 2 * IDX_W;
    localparam int RK_LO  = 64 + IDX_W;

    logic [CELL_W-1:0] r_val;
    logic [IDX_W-1:0]  own_rank;
    logic [IDX_W-1:0]  left_rank;
    logic [IDX_W-1:0]  right_rank;
    logic              is_lower;
    logic              is_upper;

    assign own_rank   = r_val[RK_LO +: IDX_W];
    assign left_rank  = i_left[RK_LO +: IDX_W];
    assign right_rank = i_right[RK_LO +: IDX_W];

    // Pair roles for the current odd-even transposition phase.
    assign is_lower = ((K % 2) == int'(i_ctl.phase)) && (CNT_W'(K + 1) < i_n);
    assign is_upper = (K >= 1) && (((K + 1) % 2) == int'(i_ctl.phase))
                      && (CNT_W'(K) < i_n);

    // Cell update.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            pmp_pkg::CELL_LOAD: begin
                if (i_wr_idx == CNT_W'(K)) begin
                    r_val <= {IDX_W'(0), IDX_W'(K), i_ld_point};
                end
            end
            pmp_pkg::CELL_ROT: begin
                if (CNT_W'(K + 1) == i_n) begin
                    r_val <= i_head;
                end else if (CNT_W'(K) < i_n) begin
                    r_val <= i_right;
                end
            end
            pmp_pkg::CELL_RANK: begin
                if (K == 0) begin
                    r_val[RK_LO +: IDX_W] <= i_rank;
                end
            end
            pmp_pkg::CELL_SWAP: begin
                if (is_lower && (own_rank > right_rank)) begin
                    r_val <= i_right;
                end else if (is_upper && (left_rank > own_rank)) begin
                    r_val <= i_left;
                end
            end
            default: begin
                r_val <= r_val;
            end
        endcase
    end

    assign o_val = r_val;

endmodule

>>> sv/pmp_mul.sv
// Shift-and-add signed multiplier that scans one bit of the narrow operand each cycle.
module pmp_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pmp_pkg::ACC_W-1:0]       i_a,
    input  logic signed [pmp_pkg::MUL_B_W-1:0]     i_b,
    output logic                                   o_done,
    output logic signed [pmp_pkg::ACC_W-1:0]       o_p
);
    localparam int W   = pmp_pkg::ACC_W;
    localparam int BW  = pmp_pkg::MUL_B_W;
    localparam int CW  = $clog2(BW);

    logic signed [W-1:0] r_a;
    logic [BW-1:0]       r_b;
    logic signed [W-1:0] r_p;
    logic [CW-1:0]       r_cnt;
    logic                r_run;
    logic                r_done;
    logic                last_bit;

    assign last_bit = (r_cnt == CW'(BW - 1));

    // Control: run flag and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && last_bit;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && last_bit) begin
                r_run <= 1'b0;
            end
        end
    end

    // Datapath: the sign bit of the narrow operand carries negative weight.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_p   <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            if (r_b[0]) begin
                r_p <= last_bit ? (r_p - r_a) : (r_p + r_a);
            end
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

>>> sv/pmp_div.sv
// Restoring signed divider, one quotient bit a cycle, rounded to nearest with halves away from zero.
module pmp_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [pmp_pkg::ACC_W-1:0]   i_num,
    input  logic signed [pmp_pkg::ACC_W-1:0]   i_den,
    output logic                               o_done,
    output logic signed [pmp_pkg::ACC_W-1:0]   o_q
);
    localparam int W  = pmp_pkg::ACC_W;
    localparam int CW = $clog2(W);

    logic [W-1:0]        r_a;
    logic [W-1:0]        r_b;
    logic [W:0]          r_r;
    logic [W-1:0]        r_quo;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic                r_run;
    logic                r_fin;
    logic                r_done;
    logic signed [W-1:0] r_q;
    logic [W:0]          trial;
    logic                fits;
    logic [W-1:0]        q_rnd;

    assign trial = {r_r[W-1:0], r_a[W-1]};
    assign fits  = (trial >= {1'b0, r_b});
    assign q_rnd = r_quo + W'({r_r[W-1:0], 1'b0} >= {1'b0, r_b});

    // Control: iteration, rounding cycle and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_run && (r_cnt == CW'(W - 1));
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == CW'(W - 1))) begin
                r_run <= 1'b0;
            end
        end
    end

    // Datapath: divide magnitudes, then round and apply the sign.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_num[W-1] ? W'(-i_num) : W'(i_num);
            r_b   <= i_den[W-1] ? W'(-i_den) : W'(i_den);
            r_neg <= i_num[W-1] ^ i_den[W-1];
            r_r   <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_run) begin
            r_r   <= fits ? (trial - {1'b0, r_b}) : trial;
            r_quo <= {r_quo[W-2:0], fits};
            r_a   <= r_a << 1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_fin) begin
            r_q <= r_neg ? signed'(-q_rnd) : signed'(q_rnd);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

>>> sv/polygon_mass_properties.sv
// Point words are taken one per cycle while the block is idle (busy low); after the last point,
// busy stays high until the result strobe. The work is set by the shared bit-serial multiplier
// (2*n^2 rank products for n >= 3 points) and the bit-serial divider. One link is worked on at a time.
// The result word is strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the point chain and returns to idle.
module polygon_mass_properties #(
    parameter int MAX_POINTS = pmp_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  pmp_pkg::t_in_word   i_item,
    output logic                busy,
    output logic                o_result_valid,
    output pmp_pkg::t_out_word  o_result
);
    localparam int W      = pmp_pkg::ACC_W;
    localparam int BW     = pmp_pkg::MUL_B_W;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int AX_W   = 32 + CNT_W + 1;
    localparam int CELL_W = 64 + 2 * IDX_W;

    // State and datapath registers.
    pmp_pkg::t_state     r_state, n_state;
    logic [3:0]          r_step, n_step;
    logic                r_wait, n_wait;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_err, n_err;
    logic signed [31:0]  r_mass, n_mass;
    logic signed [31:0]  r_gcx, n_gcx;
    logic signed [31:0]  r_gcy, n_gcy;
    logic signed [AX_W-1:0] r_sx, n_sx;
    logic signed [AX_W-1:0] r_sy, n_sy;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic signed [AX_W-1:0] r_cur_ax, n_cur_ax;
    logic signed [AX_W-1:0] r_cur_ay, n_cur_ay;
    logic [IDX_W-1:0]    r_cur_idx, n_cur_idx;
    logic [1:0]          r_cur_cls, n_cur_cls;
    logic [IDX_W-1:0]    r_rank, n_rank;
    logic signed [W-1:0] r_t1, n_t1;
    logic signed [W-1:0] r_t2, n_t2;
    logic signed [W-1:0] r_acc_d, n_acc_d;
    logic signed [W-1:0] r_acc_x, n_acc_x;
    logic signed [W-1:0] r_acc_y, n_acc_y;
    logic signed [W-1:0] r_acc_s, n_acc_s;
    logic signed [31:0]  r_cx, n_cx;
    logic signed [31:0]  r_cy, n_cy;
    logic [62:0]         r_inertia, n_inertia;
    logic                r_valid, n_valid;
    pmp_pkg::t_out_word  r_out, n_out;

    // Chain, multiplier and divider connections.
    pmp_pkg::t_cell_ctl  cell_ctl;
    logic [CELL_W-1:0]   cell_q [MAX_POINTS];
    logic                mul_start, mul_done;
    logic signed [W-1:0] mul_a, mul_p;
    logic signed [BW-1:0] mul_b;
    logic                div_start, div_done;
    logic signed [W-1:0] div_num, div_den, div_q;

    // Head and next point of the chain.
    logic signed [31:0]  hx, hy, nx, ny;
    logic [IDX_W-1:0]    h_idx;
    logic signed [AX_W-1:0] ax_h, ay_h;
    logic [1:0]          cls_h;
    logic signed [32:0]  ui, uj, vi, vj, dx, dy, sum_x, sum_y;
    logic signed [W-1:0] cross_w, d3, den_i;
    logic [31:0]         mass_abs;
    logic                same_cls, even_cls, cross_pos, cross_zero, h_first, equiv, inc;

    assign hx    = signed'(cell_q[0][31:0]);
    assign hy    = signed'(cell_q[0][63:32]);
    assign h_idx = cell_q[0][64 +: IDX_W];
    assign nx    = signed'(cell_q[1][31:0]);
    assign ny    = signed'(cell_q[1][63:32]);

    // Offset of the head from the mean, scaled by the point count.
    assign ax_h  = AX_W'(signed'({1'b0, r_count})) * AX_W'(hx) - r_sx;
    assign ay_h  = AX_W'(signed'({1'b0, r_count})) * AX_W'(hy) - r_sy;
    assign cls_h = pmp_pkg::angle_class(ay_h[AX_W-1], ay_h == '0, ax_h[AX_W-1]);

    // Angle order of the head against the point being ranked.
    assign cross_w    = r_t1 - r_t2;
    assign same_cls   = (cls_h == r_cur_cls);
    assign even_cls   = !cls_h[0];
    assign cross_zero = (cross_w == '0);
    assign cross_pos  = !cross_w[W-1] && !cross_zero;
    assign h_first    = (cls_h < r_cur_cls) || (same_cls && even_cls && cross_pos);
    assign equiv      = same_cls && (!even_cls || cross_zero);
    assign inc        = (h_idx != r_cur_idx) && (h_first || (equiv && (h_idx < r_cur_idx)));

    // Edge terms relative to the centre.
    assign ui    = 33'(hx) - 33'(r_cx);
    assign uj    = 33'(nx) - 33'(r_cx);
    assign vi    = 33'(hy) - 33'(r_cy);
    assign vj    = 33'(ny) - 33'(r_cy);
    assign sum_x = 33'(hx) + 33'(nx);
    assign sum_y = 33'(hy) + 33'(ny);
    assign dx    = 33'(hx) - ((r_count == CNT_W'(1)) ? 33'(r_gcx) : 33'(nx));
    assign dy    = 33'(hy) - ((r_count == CNT_W'(1)) ? 33'(r_gcy) : 33'(ny));

    assign mass_abs = r_mass[31] ? 32'(-r_mass) : 32'(r_mass);
    assign d3       = r_acc_d + (r_acc_d <<< 1);

    // Inertia divisor: rod forms for one or two points, 6*D for a polygon, all scaled by 2^32.
    always_comb begin
        if (r_count == CNT_W'(1)) begin
            den_i = W'(pmp_pkg::ROD_END_DIV) <<< 32;
        end else if (r_count == CNT_W'(2)) begin
            den_i = W'(pmp_pkg::ROD_MID_DIV) <<< 32;
        end else begin
            den_i = ((r_acc_d <<< 2) + (r_acc_d <<< 1)) <<< 32;
        end
    end

    // Point chain.
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        logic [CELL_W-1:0] left_val;
        logic [CELL_W-1:0] right_val;
        if (k == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_q[k-1];
        end
        if (k == MAX_POINTS - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_q[k+1];
        end
        pmp_cell #(
            .K          (k),
            .MAX_POINTS (MAX_POINTS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_n        (r_count),
            .i_wr_idx   (r_count),
            .i_ld_point ({i_item.point_y, i_item.point_x}),
            .i_rank     (r_rank),
            .i_left     (left_val),
            .i_right    (right_val),
            .i_head     (cell_q[0]),
            .o_val      (cell_q[k])
        );
    end

    pmp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    pmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // Multiplier operand selection by state and step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            pmp_pkg::ST_RANK_CMP: begin
                if (r_step == 4'd0) begin
                    mul_a = W'(ax_h);
                    mul_b = BW'(r_cur_ay);
                end else begin
                    mul_a = W'(ay_h);
                    mul_b = BW'(r_cur_ax);
                end
            end
            pmp_pkg::ST_PASS_A: begin
                case (r_step)
                    4'd0:    begin mul_a = W'(hx);  mul_b = BW'(ny);    end
                    4'd1:    begin mul_a = W'(hy);  mul_b = BW'(nx);    end
                    4'd2:    begin mul_a = cross_w; mul_b = BW'(sum_x); end
                    default: begin mul_a = cross_w; mul_b = BW'(sum_y); end
                endcase
            end
            pmp_pkg::ST_PASS_B: begin
                case (r_step)
                    4'd0:    begin mul_a = W'(uj);                mul_b = BW'(uj); end
                    4'd1:    begin mul_a = W'(ui);                mul_b = BW'(ui); end
                    4'd2:    begin mul_a = W'(34'(vj) - 34'(vi)); mul_b = BW'(34'(uj) + 34'(ui)); end
                    4'd4:    begin mul_a = W'(vj);                mul_b = BW'(vj); end
                    4'd5:    begin mul_a = W'(vi);                mul_b = BW'(vi); end
                    4'd6:    begin mul_a = W'(34'(uj) - 34'(ui)); mul_b = BW'(34'(vj) + 34'(vi)); end
                    default: begin mul_a = r_t2;                  mul_b = r_t1[BW-1:0]; end
                endcase
            end
            pmp_pkg::ST_SQ: begin
                if (r_step == 4'd0) begin
                    mul_a = W'(dx);
                    mul_b = BW'(dx);
                end else begin
                    mul_a = W'(dy);
                    mul_b = BW'(dy);
                end
            end
            pmp_pkg::ST_NUM: begin
                mul_a = r_acc_s;
                mul_b = BW'({1'b0, mass_abs});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operand selection.
    always_comb begin
        unique case (r_state)
            pmp_pkg::ST_DIV_CX: begin
                div_num = r_acc_x;
                div_den = d3;
            end
            pmp_pkg::ST_DIV_CY: begin
                div_num = r_acc_y;
                div_den = d3;
            end
            default: begin
                div_num = r_t1;
                div_den = den_i;
            end
        endcase
    end

    // State register and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmp_pkg::ST_IDLE;
            r_step  <= '0;
            r_wait  <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_err   <= 1'b0;
            r_mass  <= '0;
            r_gcx   <= '0;
            r_gcy   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_wait  <= n_wait;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_err   <= n_err;
            r_mass  <= n_mass;
            r_gcx   <= n_gcx;
            r_gcy   <= n_gcy;
            r_i     <= n_i;
            r_j     <= n_j;
            r_valid <= n_valid;
        end
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_cur_ax  <= n_cur_ax;
        r_cur_ay  <= n_cur_ay;
        r_cur_idx <= n_cur_idx;
        r_cur_cls <= n_cur_cls;
        r_rank    <= n_rank;
        r_t1      <= n_t1;
        r_t2      <= n_t2;
        r_acc_d   <= n_acc_d;
        r_acc_x   <= n_acc_x;
        r_acc_y   <= n_acc_y;
        r_acc_s   <= n_acc_s;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_inertia <= n_inertia;
        r_out     <= n_out;
    end

    // Next state, sequencing of products and quotients, chain control.
    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_wait    = r_wait;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_err     = r_err;
        n_mass    = r_mass;
        n_gcx     = r_gcx;
        n_gcy     = r_gcy;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_i       = r_i;
        n_j       = r_j;
        n_cur_ax  = r_cur_ax;
        n_cur_ay  = r_cur_ay;
        n_cur_idx = r_cur_idx;
        n_cur_cls = r_cur_cls;
        n_rank    = r_rank;
        n_t1      = r_t1;
        n_t2      = r_t2;
        n_acc_d   = r_acc_d;
        n_acc_x   = r_acc_x;
        n_acc_y   = r_acc_y;
        n_acc_s   = r_acc_s;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_inertia = r_inertia;
        n_valid   = 1'b0;
        n_out     = r_out;
        cell_ctl  = '{op: pmp_pkg::CELL_HOLD, phase: 1'b0};
        mul_start = 1'b0;
        div_start = 1'b0;

        unique case (r_state)
            // Take one point word per cycle.
            pmp_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_count == '0) begin
                        n_mass = i_item.mass_value;
                        n_gcx  = i_item.given_centre_x;
                        n_gcy  = i_item.given_centre_y;
                        n_sx   = AX_W'(i_item.point_x);
                        n_sy   = AX_W'(i_item.point_y);
                    end else if (r_count < CNT_W'(MAX_POINTS)) begin
                        n_sx = r_sx + AX_W'(i_item.point_x);
                        n_sy = r_sy + AX_W'(i_item.point_y);
                    end
                    if (r_count < CNT_W'(MAX_POINTS)) begin
                        cell_ctl.op = pmp_pkg::CELL_LOAD;
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last_point) begin
                        n_step = '0;
                        n_wait = 1'b0;
                        n_i    = '0;
                        n_err  = 1'b0;
                        if (r_ovf || (r_count >= CNT_W'(MAX_POINTS))) begin
                            n_err   = 1'b1;
                            n_state = pmp_pkg::ST_DONE;
                        end else if (r_count < CNT_W'(2)) begin
                            n_acc_s = '0;
                            n_state = pmp_pkg::ST_SQ;
                        end else begin
                            n_state = pmp_pkg::ST_RANK_CUR;
                        end
                    end
                end
            end

            // Capture the point being ranked.
            pmp_pkg::ST_RANK_CUR: begin
                n_cur_ax  = ax_h;
                n_cur_ay  = ay_h;
                n_cur_idx = h_idx;
                n_cur_cls = cls_h;
                n_rank    = '0;
                n_j       = '0;
                n_step    = '0;
                n_state   = pmp_pkg::ST_RANK_CMP;
            end

            // Compare every chain point against it as the chain rotates.
            pmp_pkg::ST_RANK_CMP: begin
                if (r_step == 4'd2) begin
                    n_rank      = r_rank + IDX_W'(inc);
                    cell_ctl.op = pmp_pkg::CELL_ROT;
                    n_j         = r_j + 1'b1;
                    n_step      = '0;
                    if (CNT_W'(r_j + 1'b1) == r_count) begin
                        n_state = pmp_pkg::ST_RANK_WR;
                    end
                end else if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait = 1'b0;
                    n_step = r_step + 1'b1;
                    if (r_step == 4'd0) begin
                        n_t1 = mul_p;
                    end else begin
                        n_t2 = mul_p;
                    end
                end
            end

            pmp_pkg::ST_RANK_WR: begin
                cell_ctl.op = pmp_pkg::CELL_RANK;
                n_state     = pmp_pkg::ST_RANK_NXT;
            end

            pmp_pkg::ST_RANK_NXT: begin
                cell_ctl.op = pmp_pkg::CELL_ROT;
                n_i         = r_i + 1'b1;
                if (CNT_W'(r_i + 1'b1) == r_count) begin
                    n_j     = '0;
                    n_state = pmp_pkg::ST_SORT;
                end else begin
                    n_state = pmp_pkg::ST_RANK_CUR;
                end
            end

            // Odd-even transposition by rank.
            pmp_pkg::ST_SORT: begin
                cell_ctl = '{op: pmp_pkg::CELL_SWAP, phase: r_j[0]};
                n_j      = r_j + 1'b1;
                if (r_j == CNT_W'(MAX_POINTS - 1)) begin
                    n_i     = '0;
                    n_step  = '0;
                    n_acc_d = '0;
                    n_acc_x = '0;
                    n_acc_y = '0;
                    n_state = pmp_pkg::ST_PASS_A;
                end
            end

            // Shoelace sums over the sorted edges.
            pmp_pkg::ST_PASS_A: begin
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait = 1'b0;
                    n_step = r_step + 1'b1;
                    case (r_step)
                        4'd0: n_t1 = mul_p;
                        4'd1: n_t2 = mul_p;
                        4'd2: begin
                            n_acc_x = r_acc_x + mul_p;
                            n_acc_d = r_acc_d + cross_w;
                        end
                        default: begin
                            n_acc_y     = r_acc_y + mul_p;
                            cell_ctl.op = pmp_pkg::CELL_ROT;
                            n_i         = r_i + 1'b1;
                            n_step      = '0;
                            if (CNT_W'(r_i + 1'b1) == r_count) begin
                                n_state = pmp_pkg::ST_DIV_CX;
                            end
                        end
                    endcase
                end
            end

            // Centroid quotients; a zero area ends the link with an error.
            pmp_pkg::ST_DIV_CX: begin
                if (r_acc_d == '0) begin
                    n_err   = 1'b1;
                    n_state = pmp_pkg::ST_DONE;
                end else if (!r_wait) begin
                    div_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (div_done) begin
                    n_wait  = 1'b0;
                    n_cx    = pmp_pkg::sat32(div_q);
                    n_state = pmp_pkg::ST_DIV_CY;
                end
            end

            pmp_pkg::ST_DIV_CY: begin
                if (!r_wait) begin
                    div_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (div_done) begin
                    n_wait  = 1'b0;
                    n_cy    = pmp_pkg::sat32(div_q);
                    n_i     = '0;
                    n_step  = '0;
                    n_acc_s = '0;
                    n_state = pmp_pkg::ST_PASS_B;
                end
            end

            // Polar moment sum about the rounded centre.
            pmp_pkg::ST_PASS_B: begin
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait = 1'b0;
                    n_step = r_step + 1'b1;
                    case (r_step)
                        4'd0, 4'd4: n_t1 = mul_p;
                        4'd1, 4'd5: n_t1 = r_t1 + mul_p;
                        4'd2, 4'd6: n_t2 = mul_p;
                        4'd3:       n_acc_s = r_acc_s + mul_p;
                        default: begin
                            n_acc_s     = r_acc_s - mul_p;
                            cell_ctl.op = pmp_pkg::CELL_ROT;
                            n_i         = r_i + 1'b1;
                            n_step      = '0;
                            if (CNT_W'(r_i + 1'b1) == r_count) begin
                                n_state = pmp_pkg::ST_NUM;
                            end
                        end
                    endcase
                end
            end

            // Rod forms: squared distance and centre for one or two points.
            pmp_pkg::ST_SQ: begin
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait  = 1'b0;
                    n_step  = r_step + 1'b1;
                    n_acc_s = r_acc_s + mul_p;
                    if (r_count == CNT_W'(1)) begin
                        n_cx = r_gcx;
                        n_cy = r_gcy;
                    end else begin
                        n_cx = sum_x[32:1];
                        n_cy = sum_y[32:1];
                    end
                    if (r_step == 4'd1) begin
                        n_step  = '0;
                        n_state = pmp_pkg::ST_NUM;
                    end
                end
            end

            // Scale by the mass.
            pmp_pkg::ST_NUM: begin
                if (!r_wait) begin
                    mul_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (mul_done) begin
                    n_wait  = 1'b0;
                    n_t1    = mul_p;
                    n_state = pmp_pkg::ST_DIV_I;
                end
            end

            pmp_pkg::ST_DIV_I: begin
                if (!r_wait) begin
                    div_start = 1'b1;
                    n_wait    = 1'b1;
                end else if (div_done) begin
                    n_wait    = 1'b0;
                    n_inertia = pmp_pkg::sat63(div_q);
                    n_state   = pmp_pkg::ST_DONE;
                end
            end

            // Present the result word and empty the chain.
            pmp_pkg::ST_DONE: begin
                n_valid = 1'b1;
                if (r_err) begin
                    n_out = '{centre_x: '0, centre_y: '0, moment_of_inertia: '0,
                              mass_out: '0, error_flag: 1'b1};
                end else begin
                    n_out = '{centre_x: r_cx, centre_y: r_cy, moment_of_inertia: r_inertia,
                              mass_out: mass_abs, error_flag: 1'b0};
                end
                n_count = '0;
                n_ovf   = 1'b0;
                n_wait  = 1'b0;
                n_state = pmp_pkg::ST_IDLE;
            end

            default: begin
                n_state = pmp_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != pmp_pkg::ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_result       = r_out;

endmodule
